// ----- rtl/swmd_pkg.sv -----
// Shared types and constants for the stack with middle deletion.
// Used by swmd_ctrl, swmd_datapath and stack_with_middle_delete_core; no dependencies.
`timescale 1ns / 1ps

package swmd_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WORD_W    = 32;
    localparam int ENTRY_W   = 7;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL_MID = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_WR,
        S_POP_RD,
        S_POP_CAP,
        S_DEL_RD,
        S_DEL_CAP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DEL_DEC,
        S_VIEW,
        S_TOP_CAP,
        S_MID_CAP,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PUSH_WR,
        CMD_RD_TOP,
        CMD_RD_MID,
        CMD_CAP_POP,
        CMD_CAP_DEL,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_DEC,
        CMD_VIEW_ZERO,
        CMD_CAP_TOP,
        CMD_CAP_MID
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
    } ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic mid_has_above;
        logic shift_more;
    } sts_t;

endpackage

// ----- rtl/swmd_ctrl.sv -----
// Sequencing state machine for the stack with middle deletion.
// Depends on swmd_pkg; drives the datapath through swmd_pkg::ctl_t.
`timescale 1ns / 1ps

module swmd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [swmd_pkg::FUNC_W-1:0]   func,
    input  swmd_pkg::sts_t                sts,
    output swmd_pkg::ctl_t                ctl,
    output logic                          busy,
    output logic                          done
);

    swmd_pkg::state_t state_reg;
    swmd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swmd_pkg::S_IDLE:
            begin
                if (start)
                begin
                    // Error cases and the unused code go straight to the view readout.
                    if (func == swmd_pkg::FUNC_PUSH && !sts.full)
                    begin
                        state_next = swmd_pkg::S_PUSH_WR;
                    end
                    else if (func == swmd_pkg::FUNC_POP && !sts.empty)
                    begin
                        state_next = swmd_pkg::S_POP_RD;
                    end
                    else if (func == swmd_pkg::FUNC_DEL_MID && !sts.empty)
                    begin
                        state_next = swmd_pkg::S_DEL_RD;
                    end
                    else
                    begin
                        state_next = swmd_pkg::S_VIEW;
                    end
                end
            end
            swmd_pkg::S_PUSH_WR:  state_next = swmd_pkg::S_VIEW;
            swmd_pkg::S_POP_RD:   state_next = swmd_pkg::S_POP_CAP;
            swmd_pkg::S_POP_CAP:  state_next = swmd_pkg::S_VIEW;
            swmd_pkg::S_DEL_RD:   state_next = swmd_pkg::S_DEL_CAP;
            swmd_pkg::S_DEL_CAP:
            begin
                state_next = sts.mid_has_above ? swmd_pkg::S_SHIFT_RD : swmd_pkg::S_DEL_DEC;
            end
            swmd_pkg::S_SHIFT_RD: state_next = swmd_pkg::S_SHIFT_WR;
            swmd_pkg::S_SHIFT_WR:
            begin
                state_next = sts.shift_more ? swmd_pkg::S_SHIFT_RD : swmd_pkg::S_DEL_DEC;
            end
            swmd_pkg::S_DEL_DEC:  state_next = swmd_pkg::S_VIEW;
            swmd_pkg::S_VIEW:
            begin
                state_next = sts.empty ? swmd_pkg::S_DONE : swmd_pkg::S_TOP_CAP;
            end
            swmd_pkg::S_TOP_CAP:  state_next = swmd_pkg::S_MID_CAP;
            swmd_pkg::S_MID_CAP:  state_next = swmd_pkg::S_DONE;
            swmd_pkg::S_DONE:     state_next = swmd_pkg::S_IDLE;
            default:              state_next = swmd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.cmd = swmd_pkg::CMD_NONE;
        busy    = 1'b1;
        done    = 1'b0;
        case (state_reg)
            swmd_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.cmd = swmd_pkg::CMD_LOAD;
                end
            end
            swmd_pkg::S_PUSH_WR:  ctl.cmd = swmd_pkg::CMD_PUSH_WR;
            swmd_pkg::S_POP_RD:   ctl.cmd = swmd_pkg::CMD_RD_TOP;
            swmd_pkg::S_POP_CAP:  ctl.cmd = swmd_pkg::CMD_CAP_POP;
            swmd_pkg::S_DEL_RD:   ctl.cmd = swmd_pkg::CMD_RD_MID;
            swmd_pkg::S_DEL_CAP:  ctl.cmd = swmd_pkg::CMD_CAP_DEL;
            swmd_pkg::S_SHIFT_RD: ctl.cmd = swmd_pkg::CMD_SHIFT_RD;
            swmd_pkg::S_SHIFT_WR: ctl.cmd = swmd_pkg::CMD_SHIFT_WR;
            swmd_pkg::S_DEL_DEC:  ctl.cmd = swmd_pkg::CMD_DEC;
            swmd_pkg::S_VIEW:
            begin
                ctl.cmd = sts.empty ? swmd_pkg::CMD_VIEW_ZERO : swmd_pkg::CMD_RD_TOP;
            end
            swmd_pkg::S_TOP_CAP:  ctl.cmd = swmd_pkg::CMD_CAP_TOP;
            swmd_pkg::S_MID_CAP:  ctl.cmd = swmd_pkg::CMD_CAP_MID;
            swmd_pkg::S_DONE:     done    = 1'b1;
            default:              ctl.cmd = swmd_pkg::CMD_NONE;
        endcase
    end

endmodule

// ----- rtl/swmd_datapath.sv -----
// Word store, count and result registers for the stack with middle deletion.
// Depends on swmd_pkg; obeys commands from swmd_ctrl and reports status flags.
`timescale 1ns / 1ps

module swmd_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  swmd_pkg::ctl_t                  ctl,
    input  logic [swmd_pkg::FUNC_W-1:0]     func,
    input  swmd_pkg::word_t                 push_value,
    output swmd_pkg::sts_t                  sts,
    output swmd_pkg::word_t                 removed_value,
    output swmd_pkg::word_t                 top_value,
    output swmd_pkg::word_t                 middle_value,
    output logic [swmd_pkg::ENTRY_W-1:0]    entry_count,
    output logic [swmd_pkg::STATUS_W-1:0]   status
);

    swmd_pkg::word_t mem [swmd_pkg::DEPTH];

    logic [swmd_pkg::CNT_W-1:0]    cnt_reg;
    logic [swmd_pkg::CNT_W-1:0]    cnt_next;
    logic [swmd_pkg::ADDR_W-1:0]   idx_reg;
    logic [swmd_pkg::STATUS_W-1:0] status_reg;
    swmd_pkg::word_t               value_reg;
    swmd_pkg::word_t               removed_reg;
    swmd_pkg::word_t               top_reg;
    swmd_pkg::word_t               mid_reg;
    swmd_pkg::word_t               rdata_reg;

    logic [swmd_pkg::CNT_W-1:0]    cnt_m1;
    logic [swmd_pkg::ADDR_W-1:0]   top_addr;
    logic [swmd_pkg::ADDR_W-1:0]   mid_addr;
    logic [swmd_pkg::ADDR_W-1:0]   raddr;
    logic                          re;
    logic [swmd_pkg::ADDR_W-1:0]   waddr;
    swmd_pkg::word_t               wdata;
    logic                          we;

    // The middle sits at (n-1)/2 counting from zero.
    assign cnt_m1   = cnt_reg - swmd_pkg::CNT_W'(1);
    assign top_addr = cnt_m1[swmd_pkg::ADDR_W-1:0];
    assign mid_addr = cnt_m1[swmd_pkg::ADDR_W:1];

    assign sts.empty         = (cnt_reg == '0);
    assign sts.full          = (cnt_reg == swmd_pkg::CNT_W'(swmd_pkg::DEPTH));
    assign sts.mid_has_above = (swmd_pkg::CNT_W'(mid_addr) + swmd_pkg::CNT_W'(1)) < cnt_reg;
    assign sts.shift_more    = (swmd_pkg::CNT_W'(idx_reg) + swmd_pkg::CNT_W'(2)) < cnt_reg;

    always_comb
    begin
        re    = 1'b0;
        raddr = top_addr;
        we    = 1'b0;
        waddr = top_addr;
        wdata = rdata_reg;
        case (ctl.cmd)
            swmd_pkg::CMD_RD_TOP:
            begin
                re    = 1'b1;
                raddr = top_addr;
            end
            swmd_pkg::CMD_RD_MID,
            swmd_pkg::CMD_CAP_TOP:
            begin
                re    = 1'b1;
                raddr = mid_addr;
            end
            swmd_pkg::CMD_SHIFT_RD:
            begin
                re    = 1'b1;
                raddr = idx_reg + swmd_pkg::ADDR_W'(1);
            end
            swmd_pkg::CMD_PUSH_WR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[swmd_pkg::ADDR_W-1:0];
                wdata = value_reg;
            end
            swmd_pkg::CMD_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg;
                wdata = rdata_reg;
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        case (ctl.cmd)
            swmd_pkg::CMD_PUSH_WR: cnt_next = cnt_reg + swmd_pkg::CNT_W'(1);
            swmd_pkg::CMD_CAP_POP,
            swmd_pkg::CMD_DEC:     cnt_next = cnt_m1;
            default:               cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            status_reg <= swmd_pkg::ST_OK;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (ctl.cmd == swmd_pkg::CMD_LOAD)
            begin
                if (func == swmd_pkg::FUNC_PUSH && sts.full)
                begin
                    status_reg <= swmd_pkg::ST_OVER;
                end
                else if ((func == swmd_pkg::FUNC_POP || func == swmd_pkg::FUNC_DEL_MID)
                         && sts.empty)
                begin
                    status_reg <= swmd_pkg::ST_UNDER;
                end
                else
                begin
                    status_reg <= swmd_pkg::ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            swmd_pkg::CMD_LOAD:
            begin
                value_reg   <= push_value;
                removed_reg <= '0;
            end
            swmd_pkg::CMD_CAP_POP:
            begin
                removed_reg <= rdata_reg;
            end
            swmd_pkg::CMD_CAP_DEL:
            begin
                removed_reg <= rdata_reg;
                idx_reg     <= mid_addr;
            end
            swmd_pkg::CMD_SHIFT_WR:
            begin
                idx_reg <= idx_reg + swmd_pkg::ADDR_W'(1);
            end
            swmd_pkg::CMD_VIEW_ZERO:
            begin
                top_reg <= '0;
                mid_reg <= '0;
            end
            swmd_pkg::CMD_CAP_TOP:
            begin
                top_reg <= rdata_reg;
            end
            swmd_pkg::CMD_CAP_MID:
            begin
                mid_reg <= rdata_reg;
            end
            default:
            begin
                value_reg <= value_reg;
            end
        endcase
    end

    assign removed_value = removed_reg;
    assign top_value     = top_reg;
    assign middle_value  = mid_reg;
    assign entry_count   = swmd_pkg::ENTRY_W'(cnt_reg);
    assign status        = status_reg;

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cmd == swmd_pkg::CMD_PUSH_WR |=> cnt_reg == $past(cnt_reg) + swmd_pkg::CNT_W'(1))
        else $error("push did not raise the count by one");

    a_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd == swmd_pkg::CMD_DEC || ctl.cmd == swmd_pkg::CMD_CAP_POP)
        |=> cnt_reg == $past(cnt_reg) - swmd_pkg::CNT_W'(1))
        else $error("removal did not lower the count by one");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cmd == swmd_pkg::CMD_SHIFT_RD
        |-> (swmd_pkg::CNT_W'(idx_reg) + swmd_pkg::CNT_W'(1)) < cnt_reg)
        else $error("shift read beyond the stored words");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cmd == swmd_pkg::CMD_LOAD && func == swmd_pkg::FUNC_PUSH && sts.full)
        |=> status_reg == swmd_pkg::ST_OVER && $stable(cnt_reg))
        else $error("push on a full store not flagged as overflow");

endmodule

// ----- rtl/stack_with_middle_delete_core.sv -----
// Top level of the bounded stack with pop and middle deletion.
// Depends on swmd_pkg, swmd_ctrl and swmd_datapath.
//
//   Channel   Handshake           Fields
//   --------  ------------------  ----------------------------------------------
//   command   start & !busy       func, push_value
//   result    done (one cycle)    removed_value, top_value, middle_value,
//                                 entry_count, status
//
// A command runs through one word store with registered reads, one access a cycle.
// A push writes its word and a pop captures the top word. Middle deletion captures the
// middle word and moves the floor(n/2) words above it down, a read and a write for each.
// Every command ends by capturing the new top and middle words, or zeros when empty.
// busy stays high until the done cycle has passed; the receiver cannot stall.
// Reset clears the count and the sequencer; the store itself is not cleared.
`timescale 1ns / 1ps

module stack_with_middle_delete_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [swmd_pkg::FUNC_W-1:0]     func,
    input  logic signed [31:0]              push_value,
    output logic                            busy,
    output logic                            done,
    output logic signed [31:0]              removed_value,
    output logic signed [31:0]              top_value,
    output logic signed [31:0]              middle_value,
    output logic [swmd_pkg::ENTRY_W-1:0]    entry_count,
    output logic [swmd_pkg::STATUS_W-1:0]   status
);

    swmd_pkg::ctl_t ctl;
    swmd_pkg::sts_t sts;

    swmd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    swmd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .func          (func),
        .push_value    (push_value),
        .sts           (sts),
        .removed_value (removed_value),
        .top_value     (top_value),
        .middle_value  (middle_value),
        .entry_count   (entry_count),
        .status        (status)
    );

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for stack_with_middle_delete_core: directed table, then random traffic.
// Depends on swmd_pkg and the RTL top; a stack model predicts results not given in the table.
`timescale 1ns / 1ps

module tb_top;

    import swmd_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [31:0]         removed;
        logic [31:0]         top;
        logic [31:0]         middle;
        logic [ENTRY_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } stack_view_t;

    // A row with reps above one sends its command that many times with random words.
    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [31:0]       value;
        logic [6:0]        reps;
        logic              typed;
        stack_view_t       view;
    } cmd_row_t;

    localparam int N_ROWS = 23;
    localparam cmd_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{FUNC_POP,     32'd0,        7'd1,  1'b1, '{32'd0, 32'd0, 32'd0, 7'd0, ST_UNDER}},
        '{FUNC_DEL_MID, 32'd0,        7'd1,  1'b1, '{32'd0, 32'd0, 32'd0, 7'd0, ST_UNDER}},
        '{FUNC_UNUSED,  32'hDEADBEEF, 7'd1,  1'b1, '{32'd0, 32'd0, 32'd0, 7'd0, ST_OK}},
        '{FUNC_PUSH,    32'h7FFFFFFF, 7'd1,  1'b1,
            '{32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 7'd1, ST_OK}},
        '{FUNC_DEL_MID, 32'd0,        7'd1,  1'b1,
            '{32'h7FFFFFFF, 32'd0, 32'd0, 7'd0, ST_OK}},
        '{FUNC_PUSH,    32'h80000000, 7'd1,  1'b1,
            '{32'd0, 32'h80000000, 32'h80000000, 7'd1, ST_OK}},
        '{FUNC_POP,     32'd0,        7'd1,  1'b1,
            '{32'h80000000, 32'd0, 32'd0, 7'd0, ST_OK}},
        '{FUNC_PUSH,    32'd1,        7'd1,  1'b1, '{32'd0, 32'd1, 32'd1, 7'd1, ST_OK}},
        '{FUNC_PUSH,    32'd2,        7'd1,  1'b1, '{32'd0, 32'd2, 32'd1, 7'd2, ST_OK}},
        '{FUNC_PUSH,    32'd3,        7'd1,  1'b1, '{32'd0, 32'd3, 32'd2, 7'd3, ST_OK}},
        '{FUNC_PUSH,    32'd4,        7'd1,  1'b1, '{32'd0, 32'd4, 32'd2, 7'd4, ST_OK}},
        '{FUNC_DEL_MID, 32'd0,        7'd1,  1'b1, '{32'd2, 32'd4, 32'd3, 7'd3, ST_OK}},
        '{FUNC_UNUSED,  32'hFFFFFFFF, 7'd1,  1'b0, '0},
        '{FUNC_PUSH,    32'hFFFFFFFF, 7'd1,  1'b0, '0},
        '{FUNC_PUSH,    32'h00000000, 7'd1,  1'b0, '0},
        '{FUNC_DEL_MID, 32'd0,        7'd1,  1'b0, '0},
        '{FUNC_POP,     32'd0,        7'd1,  1'b0, '0},
        '{FUNC_PUSH,    32'd0,        7'd60, 1'b0, '0},
        '{FUNC_PUSH,    32'h7FFFFFFF, 7'd1,  1'b0, '0},
        '{FUNC_PUSH,    32'h80000000, 7'd1,  1'b0, '0},
        '{FUNC_DEL_MID, 32'd0,        7'd1,  1'b0, '0},
        '{FUNC_PUSH,    32'd5,        7'd1,  1'b0, '0},
        '{FUNC_POP,     32'd0,        7'd1,  1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [FUNC_W-1:0]    func;
    logic signed [31:0]   push_value;
    logic                 busy;
    logic                 done;
    logic signed [31:0]   removed_value;
    logic signed [31:0]   top_value;
    logic signed [31:0]   middle_value;
    logic [ENTRY_W-1:0]   entry_count;
    logic [STATUS_W-1:0]  status;

    logic [31:0]  shadow_words [DEPTH];
    int           shadow_fill;
    stack_view_t  expected_views [$];
    stack_view_t  oldest_view;
    int           mismatch_count;
    int           idle_pct;

    stack_with_middle_delete_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .push_value    (push_value),
        .busy          (busy),
        .done          (done),
        .removed_value (removed_value),
        .top_value     (top_value),
        .middle_value  (middle_value),
        .entry_count   (entry_count),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Applies one command to the shadow stack and returns the view it should report.
    function automatic stack_view_t apply_stack_op(logic [FUNC_W-1:0] op, logic [31:0] val);
        stack_view_t r;
        int          m;
        r = '0;
        r.status = ST_OK;
        case (op)
            FUNC_PUSH:
                if (shadow_fill >= DEPTH)
                    r.status = ST_OVER;
                else
                begin
                    shadow_words[shadow_fill] = val;
                    shadow_fill++;
                end
            FUNC_POP:
                if (shadow_fill == 0)
                    r.status = ST_UNDER;
                else
                begin
                    shadow_fill--;
                    r.removed = shadow_words[shadow_fill];
                end
            FUNC_DEL_MID:
                if (shadow_fill == 0)
                    r.status = ST_UNDER;
                else
                begin
                    m = (shadow_fill - 1) / 2;
                    r.removed = shadow_words[m];
                    for (int i = m; i + 1 < shadow_fill; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_fill--;
                end
            default: ;
        endcase
        if (shadow_fill != 0)
        begin
            r.top    = shadow_words[shadow_fill - 1];
            r.middle = shadow_words[(shadow_fill - 1) / 2];
        end
        r.count = shadow_fill[ENTRY_W-1:0];
        return r;
    endfunction

    task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Presents one command and holds it until the transfer happens.
    task automatic send_command(logic [FUNC_W-1:0] op, logic [31:0] val, bit typed,
                                stack_view_t typed_view);
        stack_view_t predicted;
        @(negedge clk);
        start      = 1'b1;
        func       = op;
        push_value = val;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_stack_op(op, val);
        expected_views.push_back(typed ? typed_view : predicted);
    endtask

    // Sender gaps; the port fields carry junk while start is low.
    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start      = 1'b0;
            func       = FUNC_W'($urandom);
            push_value = $urandom;
        end
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h00000000;
            3: return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_views.size() == 0)
                log_mismatch("result with no command waiting", removed_value, 32'd0);
            else
            begin
                oldest_view = expected_views.pop_front();
                if (removed_value !== oldest_view.removed)
                    log_mismatch("removed_value", removed_value, oldest_view.removed);
                if (top_value !== oldest_view.top)
                    log_mismatch("top_value", top_value, oldest_view.top);
                if (middle_value !== oldest_view.middle)
                    log_mismatch("middle_value", middle_value, oldest_view.middle);
                if (entry_count !== oldest_view.count)
                    log_mismatch("entry_count", 32'(entry_count), 32'(oldest_view.count));
                if (status !== oldest_view.status)
                    log_mismatch("status", 32'(status), 32'(oldest_view.status));
            end
        end
    end

    initial
    begin
        int               push_pct;
        int               roll;
        logic [FUNC_W-1:0] op;
        start          = 1'b0;
        func           = FUNC_PUSH;
        push_value     = '0;
        rst_n          = 1'b0;
        shadow_fill    = 0;
        mismatch_count = 0;
        idle_pct       = 0;
        push_pct       = 50;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++)
        begin
            for (int k = 0; k < DIRECTED_ROWS[r].reps; k++)
                send_command(DIRECTED_ROWS[r].op,
                             DIRECTED_ROWS[r].reps > 1 ? $urandom : DIRECTED_ROWS[r].value,
                             DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].view);
        end

        // Idle phases rotate every 200 commands; the mix swings between filling and
        // draining so that both the full and the empty ends are hit repeatedly.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 200 == 0)
            begin
                case ((n / 200) % 3)
                    0: idle_pct = 0;
                    1: idle_pct = 68;
                    default: idle_pct = 16;
                endcase
            end
            if (n % 100 == 0)
            begin
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 4)
                op = FUNC_UNUSED;
            else if (roll < 4 + push_pct * 96 / 100)
                op = FUNC_PUSH;
            else
                op = $urandom_range(1) ? FUNC_POP : FUNC_DEL_MID;
            send_command(op, random_word(), 1'b0, '0);
            sender_gap();
        end

        @(negedge clk);
        start = 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
